// ----- rtl/recc_pkg.sv -----
// Package with the shared constants of the relay endurance cycle controller.
`timescale 1ns / 1ps

package recc_pkg;

  // Widths of the configuration registers and counters.
  localparam int OnW     = 16;
  localparam int StuckW  = 15;
  localparam int BuzzW   = 17;
  localparam int ShortW  = 10;
  localparam int CountW  = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 17;
  localparam int InW     = 8;
  localparam int OutW    = 40;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_ON_TICKS        = 3'd0,
    REG_PERIOD_TICKS    = 3'd1,
    REG_STUCK_LIMIT     = 3'd2,
    REG_BUZZER_PERIOD   = 3'd3,
    REG_BUZZER_ON_FROM  = 3'd4,
    REG_LED_HALF_PERIOD = 3'd5,
    REG_START_BEEP      = 3'd6,
    REG_FAULT_BEEP      = 3'd7
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [OnW-1:0]    OnTicksRst       = 16'd4000;
  localparam logic [OnW-1:0]    PeriodTicksRst   = 16'd8000;
  localparam logic [StuckW-1:0] StuckLimitRst    = 15'd24000;
  localparam logic [BuzzW-1:0]  BuzzerPeriodRst  = 17'd120000;
  localparam logic [BuzzW-1:0]  BuzzerOnFromRst  = 17'd118000;
  localparam logic [ShortW-1:0] LedHalfPeriodRst = 10'd1000;
  localparam logic [ShortW-1:0] StartBeepRst     = 10'd100;
  localparam logic [ShortW-1:0] FaultBeepRst     = 10'd1000;

  // The cycle count saturates one below this cap.
  localparam logic [CountW-1:0] CycleCap = 32'd4000000000;
  localparam logic [CountW-1:0] CycleMax = CycleCap - 32'd1;

endpackage

// ----- rtl/relay_endurance_cycle_controller_top.sv -----
// Top level of the relay endurance cycle controller.
`timescale 1ns / 1ps

// Each input item is one timer tick carrying the enable switch and load sensor
// pin levels; each accepted tick yields exactly one result item with the relay,
// low-side, buzzer and LED drive levels, the running and fault flags and the
// saturating count of finished relay cycles, all taken after that tick's update.
// The whole tick update (LED timer, relay phase, stuck-sensor check, buzzer
// timer, switch press, beep countdown) is a single pass of short counter and
// compare logic, so the block takes one item per clock cycle: a tick is
// accepted whenever the output register is empty or is being emptied in the
// same cycle, and its result is registered and appears on the output in the next cycle.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and should be changed only while no tick is pending; writes never touch the
// counters, so lowering a period below a running counter restarts it on the
// next tick.  A pressed switch (enable_pin low) starts the sequence and clears
// the count even after a fault, but the fault flag is sticky until reset and
// keeps the low-side drive off.

module relay_endurance_cycle_controller_top (
  input  logic                            clk,
  input  logic                            rst,
  // Tick items in.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [recc_pkg::InW-1:0]        s_tdata,   // enable_pin, sensor_pin, zero fill
  // Result items out.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [recc_pkg::OutW-1:0]       m_tdata,   // relay_drive, low_side_drive,
                                                     // buzzer_drive, led_drive, running,
                                                     // fault_flag, cycle_count, zero fill
  // Configuration writes.
  input  logic                            cfg_we,
  input  logic [recc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [recc_pkg::CfgW-1:0]       cfg_data
);

  // Configuration registers.
  logic [recc_pkg::OnW-1:0]    on_ticks;
  logic [recc_pkg::OnW-1:0]    period_ticks;
  logic [recc_pkg::StuckW-1:0] stuck_limit;
  logic [recc_pkg::BuzzW-1:0]  buzzer_period;
  logic [recc_pkg::BuzzW-1:0]  buzzer_on_from;
  logic [recc_pkg::ShortW-1:0] led_half_period;
  logic [recc_pkg::ShortW-1:0] start_beep;
  logic [recc_pkg::ShortW-1:0] fault_beep;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_ticks        <= recc_pkg::OnTicksRst;
      period_ticks    <= recc_pkg::PeriodTicksRst;
      stuck_limit     <= recc_pkg::StuckLimitRst;
      buzzer_period   <= recc_pkg::BuzzerPeriodRst;
      buzzer_on_from  <= recc_pkg::BuzzerOnFromRst;
      led_half_period <= recc_pkg::LedHalfPeriodRst;
      start_beep      <= recc_pkg::StartBeepRst;
      fault_beep      <= recc_pkg::FaultBeepRst;
    end else if (cfg_we) begin
      case (cfg_index)
        recc_pkg::REG_ON_TICKS:        on_ticks        <= cfg_data[recc_pkg::OnW-1:0];
        recc_pkg::REG_PERIOD_TICKS:    period_ticks    <= cfg_data[recc_pkg::OnW-1:0];
        recc_pkg::REG_STUCK_LIMIT:     stuck_limit     <= cfg_data[recc_pkg::StuckW-1:0];
        recc_pkg::REG_BUZZER_PERIOD:   buzzer_period   <= cfg_data[recc_pkg::BuzzW-1:0];
        recc_pkg::REG_BUZZER_ON_FROM:  buzzer_on_from  <= cfg_data[recc_pkg::BuzzW-1:0];
        recc_pkg::REG_LED_HALF_PERIOD: led_half_period <= cfg_data[recc_pkg::ShortW-1:0];
        recc_pkg::REG_START_BEEP:      start_beep      <= cfg_data[recc_pkg::ShortW-1:0];
        recc_pkg::REG_FAULT_BEEP:      fault_beep      <= cfg_data[recc_pkg::ShortW-1:0];
        default: ;
      endcase
    end
  end

  // Controller state.
  logic [recc_pkg::ShortW-1:0] led_ticks, led_ticks_next;
  logic                        led_level, led_level_next;
  logic                        enabled, enabled_next;
  logic                        fault, fault_next;
  logic                        relay_on, relay_on_next;
  logic                        low_side_on, low_side_on_next;
  logic [recc_pkg::OnW-1:0]    phase_ticks, phase_ticks_next;
  logic [recc_pkg::CountW-1:0] cycles, cycles_next;
  logic [recc_pkg::StuckW-1:0] low_run, low_run_next;
  logic [recc_pkg::StuckW-1:0] high_run, high_run_next;
  logic [recc_pkg::BuzzW-1:0]  buzzer_ticks, buzzer_ticks_next;
  logic [recc_pkg::ShortW-1:0] beep_left, beep_left_next;

  logic                        enable_pin;
  logic                        sensor_pin;
  logic                        buzz;
  logic                        raise;
  logic                        in_take;
  logic [recc_pkg::ShortW:0]   led_inc;
  logic [recc_pkg::OnW-1:0]    phase_inc;
  logic [recc_pkg::BuzzW:0]    buzz_inc;

  assign enable_pin = s_tdata[0];
  assign sensor_pin = s_tdata[1];

  // The output register is free when empty or being drained this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign in_take  = s_tvalid && s_tready;

  always_comb begin
    led_ticks_next    = led_ticks;
    led_level_next    = led_level;
    enabled_next      = enabled;
    fault_next        = fault;
    relay_on_next     = relay_on;
    low_side_on_next  = low_side_on;
    phase_ticks_next  = phase_ticks;
    cycles_next       = cycles;
    low_run_next      = low_run;
    high_run_next     = high_run;
    buzzer_ticks_next = buzzer_ticks;
    beep_left_next    = beep_left;
    raise             = 1'b0;

    // Free-running LED blink timer; the 11-bit sum catches the wrap past 1023.
    led_inc = {1'b0, led_ticks} + 11'd1;
    if (led_inc >= {1'b0, led_half_period}) begin
      led_ticks_next = '0;
      led_level_next = !led_level;
    end else begin
      led_ticks_next = led_inc[recc_pkg::ShortW-1:0];
    end

    phase_inc = phase_ticks + 16'd1;
    if (enabled) begin
      // Relay cycle: on from on_ticks, off and counted at period_ticks.
      phase_ticks_next = phase_inc;
      if (phase_inc >= on_ticks) begin
        relay_on_next = 1'b1;
        if (phase_inc >= period_ticks) begin
          phase_ticks_next = '0;
          relay_on_next    = 1'b0;
          cycles_next      = (cycles >= recc_pkg::CycleMax) ? recc_pkg::CycleMax
                                                            : cycles + 32'd1;
        end
      end
      // Stuck-sensor watch: the run of the current level counts up, the other clears.
      if (!sensor_pin) begin
        high_run_next = '0;
        if (low_run >= stuck_limit) begin
          low_run_next = '0;
          raise        = 1'b1;
        end else begin
          low_run_next = low_run + 15'd1;
        end
      end else begin
        low_run_next = '0;
        if (high_run >= stuck_limit) begin
          high_run_next = '0;
          raise         = 1'b1;
        end else begin
          high_run_next = high_run + 15'd1;
        end
      end
      if (raise) begin
        enabled_next     = 1'b0;
        fault_next       = 1'b1;
        relay_on_next    = 1'b0;
        low_side_on_next = 1'b0;
        beep_left_next   = fault_beep;
      end
    end

    // Repeating buzzer timer that frames the fault alarm window.
    buzz_inc = {1'b0, buzzer_ticks} + 18'd1;
    if (buzz_inc >= {1'b0, buzzer_period}) begin
      buzzer_ticks_next = '0;
    end else begin
      buzzer_ticks_next = buzz_inc[recc_pkg::BuzzW-1:0];
    end

    // A pressed switch (pin low) starts the sequence and clears the count.
    if (!enable_pin) begin
      enabled_next   = 1'b1;
      cycles_next    = '0;
      beep_left_next = start_beep;
    end

    if (beep_left_next != '0) begin
      beep_left_next = beep_left_next - 10'd1;
    end

    buzz = (fault_next && (buzzer_ticks_next >= buzzer_on_from)) || (beep_left_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_ticks    <= '0;
      led_level    <= 1'b0;
      enabled      <= 1'b0;
      fault        <= 1'b0;
      relay_on     <= 1'b0;
      low_side_on  <= 1'b1;
      phase_ticks  <= '0;
      cycles       <= '0;
      low_run      <= '0;
      high_run     <= '0;
      buzzer_ticks <= '0;
      beep_left    <= '0;
    end else if (in_take) begin
      led_ticks    <= led_ticks_next;
      led_level    <= led_level_next;
      enabled      <= enabled_next;
      fault        <= fault_next;
      relay_on     <= relay_on_next;
      low_side_on  <= low_side_on_next;
      phase_ticks  <= phase_ticks_next;
      cycles       <= cycles_next;
      low_run      <= low_run_next;
      high_run     <= high_run_next;
      buzzer_ticks <= buzzer_ticks_next;
      beep_left    <= beep_left_next;
    end
  end

  // Result register: holds one item until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      m_tdata <= {2'b00, cycles_next, fault_next, enabled_next, led_level_next, buzz,
                  low_side_on_next, relay_on_next};
    end
  end

  // The fault is sticky until reset.
  assert property (@(posedge clk) disable iff (rst) fault |=> fault)
    else $error("fault flag cleared without reset");

  // The low-side drive is off exactly when a fault has been raised.
  assert property (@(posedge clk) disable iff (rst) low_side_on != fault)
    else $error("low-side drive out of step with fault flag");

  // The relay can only be on while the sequence runs.
  assert property (@(posedge clk) disable iff (rst) relay_on |-> enabled)
    else $error("relay on while sequence disabled");

  // The cycle count never passes its saturation value.
  assert property (@(posedge clk) disable iff (rst) cycles <= recc_pkg::CycleMax)
    else $error("cycle count beyond saturation value");

  // Every accepted tick leaves a result in the output register.
  assert property (@(posedge clk) disable iff (rst) in_take |=> m_tvalid)
    else $error("accepted tick produced no result");

endmodule
